// ===== hw/rtl/wio_pkg.sv =====
// ----------------------------------------------------------------------------
// wio_pkg
// Shared constants and types of the wavetable oscillator core.
// ----------------------------------------------------------------------------
package wio_pkg;

  localparam int ADDR_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Hermite fraction width
  localparam int HB = 16;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_RENDER  = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] MODE_NEAREST = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_HERMITE = 2'd2;
  localparam logic [1:0] MODE_ALT     = 2'd3;

  localparam logic [2:0] REG_START_POS   = 3'd0;
  localparam logic [2:0] REG_LOOP_START  = 3'd1;
  localparam logic [2:0] REG_LOOP_END    = 3'd2;
  localparam logic [2:0] REG_END_POS     = 3'd3;
  localparam logic [2:0] REG_LOOP_ENABLE = 3'd4;
  localparam logic [2:0] REG_INTERP_MODE = 3'd5;

  localparam int Q_DEPTH = 2;
  localparam int Q_LVL_BITS = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [Q_LVL_BITS-1:0] level;
    logic                  full;
  } q_stat_t;

endpackage

// ===== hw/rtl/wio_ram.sv =====
// ----------------------------------------------------------------------------
// wio_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wio_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/wio_front.sv =====
// ----------------------------------------------------------------------------
// wio_front
// Request intake: drops no-op codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module wio_front #(
  parameter int ADDR_BITS   = wio_pkg::ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = wio_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = wio_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [ADDR_BITS-1:0]          in_address,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [FRAC_BITS+3:0]          in_step,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic [1:0]                    q_op,
  output logic [ADDR_BITS-1:0]          q_addr,
  output logic signed [SAMPLE_BITS-1:0] q_data,
  output logic [FRAC_BITS+3:0]          q_step,
  output wio_pkg::q_stat_t              q_stat
);

  localparam int PB = (wio_pkg::Q_DEPTH > 1) ? $clog2(wio_pkg::Q_DEPTH) : 1;
  localparam int LB = wio_pkg::Q_LVL_BITS;

  logic [1:0]                    op_q   [wio_pkg::Q_DEPTH];
  logic [ADDR_BITS-1:0]          addr_q [wio_pkg::Q_DEPTH];
  logic signed [SAMPLE_BITS-1:0] data_q [wio_pkg::Q_DEPTH];
  logic [FRAC_BITS+3:0]          step_q [wio_pkg::Q_DEPTH];

  logic [PB-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LB-1:0] lvl_r, lvl_nxt;
  logic          push, pop;

  assign in_stall = (lvl_r == LB'(wio_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall && (in_op != wio_pkg::OP_NOP);
  assign pop      = q_pop && q_valid;
  assign q_valid  = (lvl_r != '0);
  assign q_op     = op_q[rp_r];
  assign q_addr   = addr_q[rp_r];
  assign q_data   = data_q[rp_r];
  assign q_step   = step_q[rp_r];
  assign q_stat.level = lvl_r;
  assign q_stat.full  = in_stall;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    lvl_nxt = lvl_r;
    if (push) begin
      wp_nxt = (wp_r == PB'(wio_pkg::Q_DEPTH - 1)) ? '0 : PB'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PB'(wio_pkg::Q_DEPTH - 1)) ? '0 : PB'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      lvl_nxt = LB'(lvl_r + 1'b1);
    end else if (pop && !push) begin
      lvl_nxt = LB'(lvl_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wp_r]   <= in_op;
      addr_q[wp_r] <= in_address;
      data_q[wp_r] <= in_sample_value;
      step_q[wp_r] <= in_step;
    end
  end

endmodule

// ===== hw/rtl/wio_back.sv =====
// ----------------------------------------------------------------------------
// wio_back
// Playback engine: store writes, restart, loop wrap, tap fetch,
// interpolation and the result register.
// ----------------------------------------------------------------------------
module wio_back #(
  parameter int ADDR_BITS   = wio_pkg::ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = wio_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = wio_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ADDR_BITS-1:0]          start_pos,
  input  logic [ADDR_BITS-1:0]          lp_begin,
  input  logic [ADDR_BITS-1:0]          lp_limit,
  input  logic [ADDR_BITS-1:0]          end_pos,
  input  logic                          loop_enable,
  input  logic [1:0]                    interp_mode,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [1:0]                    q_op,
  input  logic [ADDR_BITS-1:0]          q_addr,
  input  logic signed [SAMPLE_BITS-1:0] q_data,
  input  logic [FRAC_BITS+3:0]          q_step,
  output logic                          ram_we,
  output logic [ADDR_BITS-1:0]          ram_addr,
  output logic [SAMPLE_BITS-1:0]        ram_wdata,
  input  logic [SAMPLE_BITS-1:0]        ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_active,
  output logic                          out_looped
);

  localparam int AW  = ADDR_BITS;
  localparam int SW  = SAMPLE_BITS;
  localparam int FW  = FRAC_BITS;
  localparam int PW  = AW + FW;
  localparam int STW = FW + 4;
  localparam int HB  = wio_pkg::HB;
  localparam int KW  = SW + 6;
  localparam int HW  = SW + 24;
  localparam int PHW = HW - HB;
  localparam int M1W = PHW + HB + 1;
  localparam int LW  = SW + FW + 2;
  localparam int VW  = SW + FW + 24;
  localparam int CW  = ($clog2(AW + 1) > 3) ? $clog2(AW + 1) : 3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_POS  = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_CALC = 4'd5;
  localparam logic [3:0] ST_LIN  = 4'd6;
  localparam logic [3:0] ST_H0   = 4'd7;
  localparam logic [3:0] ST_H1   = 4'd8;
  localparam logic [3:0] ST_H2   = 4'd9;
  localparam logic [3:0] ST_H3   = 4'd10;
  localparam logic [3:0] ST_H4   = 4'd11;
  localparam logic [3:0] ST_H5   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  function automatic logic signed [SW-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    hi = VW'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - VW'(1);
    if (v > hi) begin
      sat = hi[SW-1:0];
    end else if (v < lo) begin
      sat = lo[SW-1:0];
    end else begin
      sat = v[SW-1:0];
    end
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic                    flag_r, flag_nxt;
  logic                    looped_r, looped_nxt;
  logic [STW-1:0]          step_r, step_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [AW-1:0]           dvd_r, dvd_nxt;
  logic [AW-1:0]           rem_r, rem_nxt;
  logic [FW-1:0]           frac_r, frac_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [SW-1:0]    x_r [4];
  logic signed [KW-1:0]    a2_r, b2_r, c2_r;
  logic signed [HW-1:0]    p_r;
  logic signed [M1W-1:0]   m1_r;
  logic [2*HB-1:0]         m2_r;
  logic signed [LW-1:0]    lin_r;
  logic signed [SW-1:0]    val_r;
  logic                    act_r;
  logic                    out_valid_r, out_active_r, out_looped_r;
  logic signed [SW-1:0]    out_sample_r;

  logic                    wrap;
  logic [AW-1:0]           len;
  logic [PW-1:0]           le_pos;
  logic [PW-1:0]           ovr;
  logic [AW:0]             remx;
  logic [AW-1:0]           rem_step;
  logic [AW-1:0]           fl;
  logic [FW-1:0]           t;
  logic [HB-1:0]           tt;
  logic [AW+1:0]           need_idx;
  logic [AW+1:0]           ix;
  logic [1:0]              km1;
  logic [1:0]              mode_in;
  logic signed [SW:0]      dlin;
  logic signed [KW-1:0]    c2, v2, w2, a2;
  logic signed [PHW-1:0]   p_hi;
  logic signed [HW-1:0]    hsum;
  logic                    load_out;

  assign wrap     = loop_enable && (lp_limit > lp_begin);
  assign len      = AW'(lp_limit - lp_begin);
  assign le_pos   = {lp_limit, {FW{1'b0}}};
  assign ovr      = PW'(pos_r - le_pos);
  assign remx     = {rem_r, dvd_r[AW-1]};
  assign rem_step = (remx >= {1'b0, len}) ? AW'(remx - {1'b0, len}) : remx[AW-1:0];
  assign fl       = pos_r[PW-1:FW];
  assign t        = pos_r[FW-1:0];
  assign tt       = HB'({t, {HB{1'b0}}} >> FW);
  assign km1      = 2'(cnt_r - 1'b1);
  assign dlin     = (SW+1)'(x_r[1]) - (SW+1)'(x_r[0]);
  assign c2       = KW'(x_r[2]) - KW'(x_r[0]);
  assign v2       = (KW'(x_r[1]) - KW'(x_r[2])) <<< 1;
  assign w2       = c2 + v2;
  assign a2       = w2 + v2 + (KW'(x_r[3]) - KW'(x_r[1]));
  assign p_hi     = PHW'(p_r >>> HB);
  assign hsum     = HW'(m1_r) + $signed({{(HW-HB){1'b0}}, m2_r[2*HB-1:HB]});
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    case (mode_r)
      wio_pkg::MODE_NEAREST: need_idx = {2'b00, fl};
      wio_pkg::MODE_HERMITE: need_idx = (AW+2)'({2'b00, fl} + 2'd3);
      default:               need_idx = (AW+2)'({2'b00, fl} + 2'd1);
    endcase
    ix = (AW+2)'({2'b00, fl} + cnt_r[1:0]);
    if (wrap && (cnt_r[1:0] != 2'd0) && (ix >= {2'b00, lp_limit})) begin
      ix = (AW+2)'(ix - {2'b00, len});
    end
    mode_in = (interp_mode == wio_pkg::MODE_ALT) ? wio_pkg::MODE_LINEAR : interp_mode;
    if (q_step == STW'({1'b1, {FW{1'b0}}})) begin
      mode_in = wio_pkg::MODE_NEAREST;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    flag_nxt   = flag_r;
    looped_nxt = looped_r;
    step_nxt   = step_r;
    mode_nxt   = mode_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = q_addr;
    ram_wdata  = q_data;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op)
            wio_pkg::OP_WRITE: begin
              ram_we = 1'b1;
            end
            wio_pkg::OP_RESTART: begin
              pos_nxt  = {start_pos, {FW{1'b0}}};
              flag_nxt = 1'b0;
            end
            wio_pkg::OP_RENDER: begin
              step_nxt   = q_step;
              mode_nxt   = mode_in;
              looped_nxt = flag_r;
              state_nxt  = ST_CHK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHK: begin
        if (wrap && (pos_r >= le_pos)) begin
          dvd_nxt   = ovr[PW-1:FW];
          frac_nxt  = ovr[FW-1:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_POS;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[AW-2:0], 1'b0};
        cnt_nxt = CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(AW - 1)) begin
          pos_nxt    = {AW'(lp_begin + rem_step), frac_r};
          looped_nxt = 1'b1;
          state_nxt  = ST_POS;
        end
      end
      ST_POS: begin
        cnt_nxt = '0;
        if (!loop_enable && (need_idx >= {2'b00, end_pos})) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_addr = ix[AW-1:0];
        cnt_nxt  = CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(4)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        case (mode_r)
          wio_pkg::MODE_NEAREST: state_nxt = ST_FIN;
          wio_pkg::MODE_HERMITE: state_nxt = ST_H0;
          default:               state_nxt = ST_LIN;
        endcase
      end
      ST_LIN: state_nxt = ST_FIN;
      ST_H0:  state_nxt = ST_H1;
      ST_H1:  state_nxt = ST_H2;
      ST_H2:  state_nxt = ST_H3;
      ST_H3:  state_nxt = ST_H4;
      ST_H4:  state_nxt = ST_H5;
      ST_H5:  state_nxt = ST_FIN;
      ST_FIN: begin
        pos_nxt   = PW'(pos_r + PW'(step_r));
        flag_nxt  = looped_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      flag_r  <= flag_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    looped_r <= looped_nxt;
    step_r   <= step_nxt;
    mode_r   <= mode_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    frac_r   <= frac_nxt;
    cnt_r    <= cnt_nxt;
    if ((state_r == ST_RD) && (cnt_r != '0)) begin
      x_r[km1] <= $signed(ram_rdata);
    end
    case (state_r)
      ST_POS: begin
        val_r <= '0;
        act_r <= 1'b0;
      end
      ST_CALC: begin
        val_r <= x_r[0];
        lin_r <= (LW'(x_r[0]) <<< FW) + LW'(dlin) * $signed({1'b0, t});
        c2_r  <= c2;
        a2_r  <= a2;
        b2_r  <= w2 + a2;
      end
      ST_LIN: begin
        val_r <= sat(VW'((lin_r + $signed(LW'({1'b1, {(FW-1){1'b0}}}))) >>> FW));
      end
      ST_H0: begin
        p_r <= HW'(a2_r) * $signed({1'b0, tt}) - (HW'(b2_r) <<< HB);
      end
      ST_H1, ST_H3: begin
        m1_r <= M1W'(p_hi) * $signed({1'b0, tt});
        m2_r <= p_r[HB-1:0] * tt;
      end
      ST_H2: begin
        p_r <= hsum + (HW'(c2_r) <<< HB);
      end
      ST_H4: begin
        p_r <= hsum + (HW'(x_r[1]) <<< (HB + 1));
      end
      ST_H5: begin
        val_r <= sat(VW'((p_r + (HW'(1) <<< HB)) >>> (HB + 1)));
      end
      ST_FIN: begin
        act_r <= 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_sample_r <= val_r;
      out_active_r <= act_r;
      out_looped_r <= act_r ? looped_r : flag_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_active     = out_active_r;
  assign out_looped     = out_looped_r;

endmodule

// ===== hw/rtl/wavetable_interpolating_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// wavetable_interpolating_oscillator_core
// Sample-playback voice with nearest, linear and Hermite interpolation.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time by the
// engine; no-op codes are dropped at intake. A store write or restart is done
// as it is popped. A render checks for a loop wrap (a bit-serial remainder
// when the position wraps inside the loop), then for the end of playback,
// where it goes straight to the output; else it fetches the four taps one
// per cycle through the single sample RAM port and interpolates, by the
// Horner multiply chain for Hermite. The result waits in an output register
// while the queue keeps taking requests.
module wavetable_interpolating_oscillator_core #(
  parameter int ADDR_BITS   = wio_pkg::ADDR_BITS_DEF,
  parameter int SAMPLE_BITS = wio_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = wio_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [ADDR_BITS-1:0]          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [ADDR_BITS-1:0]          in_address,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic [FRAC_BITS+3:0]          in_step,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_active,
  output logic                          out_looped
);

  logic [ADDR_BITS-1:0] start_pos_r, loop_start_r, loop_end_r, end_pos_r;
  logic                 loop_enable_r;
  logic [1:0]           interp_mode_r;

  logic                          q_valid, q_pop;
  logic [1:0]                    q_op;
  logic [ADDR_BITS-1:0]          q_addr;
  logic signed [SAMPLE_BITS-1:0] q_data;
  logic [FRAC_BITS+3:0]          q_step;
  wio_pkg::q_stat_t              q_stat;

  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r   <= '0;
      loop_start_r  <= '0;
      loop_end_r    <= ADDR_BITS'(1);
      end_pos_r     <= '0;
      loop_enable_r <= 1'b0;
      interp_mode_r <= wio_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        wio_pkg::REG_START_POS:   start_pos_r   <= cfg_wdata;
        wio_pkg::REG_LOOP_START:  loop_start_r  <= cfg_wdata;
        wio_pkg::REG_LOOP_END:    loop_end_r    <= cfg_wdata;
        wio_pkg::REG_END_POS:     end_pos_r     <= cfg_wdata;
        wio_pkg::REG_LOOP_ENABLE: loop_enable_r <= cfg_wdata[0];
        wio_pkg::REG_INTERP_MODE: interp_mode_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  wio_front #(
    .ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_address(in_address), .in_sample_value(in_sample_value), .in_step(in_step),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_addr(q_addr),
    .q_data(q_data), .q_step(q_step), .q_stat(q_stat)
  );

  wio_ram #(
    .WIDTH(SAMPLE_BITS), .DEPTH(1 << ADDR_BITS)
  ) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  wio_back #(
    .ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .start_pos(start_pos_r), .lp_begin(loop_start_r), .lp_limit(loop_end_r),
    .end_pos(end_pos_r), .loop_enable(loop_enable_r), .interp_mode(interp_mode_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_addr(q_addr),
    .q_data(q_data), .q_step(q_step),
    .ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata), .ram_rdata(ram_rdata),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .out_active(out_active), .out_looped(out_looped)
  );

`ifndef SYNTHESIS
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= wio_pkg::Q_LVL_BITS'(wio_pkg::Q_DEPTH))
    else $error("queue level out of range");
  a_q_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == q_stat.full && (q_stat.full == (q_stat.level != '0 && !q_valid) ||
    q_stat.full == (q_stat.level == wio_pkg::Q_LVL_BITS'(wio_pkg::Q_DEPTH))))
    else $error("stall does not follow queue fill");
  a_ended_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_sample_out == '0)
    else $error("ended playback with nonzero sample");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
